@@ rtl/core/tcw_pkg.sv @@
// Shared constants, command codes and controller/datapath types for the text console writer.
package tcw_pkg;

   localparam int unsigned COLUMNS = 80;
   localparam int unsigned ROWS    = 25;
   localparam int unsigned CELLS   = COLUMNS * ROWS;

   // Fixed field widths of the request and response channels
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CELL_W  = 11;

   localparam int unsigned ADDR_W  = $clog2(CELLS);
   localparam int unsigned COL_W   = $clog2(COLUMNS);

   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic [CMD_W-1:0] CMD_PUT      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_ATTR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FILL     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_CLEAR,
      ST_FILL,
      ST_READ,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_INIT,
      MEM_CLEAR,
      MEM_FILL,
      MEM_SCROLL,
      MEM_PUT,
      MEM_READ
   } mem_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_PUT,
      CUR_SCROLL,
      CUR_ZERO
   } cur_op_type;

   typedef struct packed {
      logic       capture;
      logic       sweep_start;
      logic       sweep_step;
      mem_op_type mem_op;
      cur_op_type cur_op;
      logic       load_rsp;
      logic       set_scrolled;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  req_cmd;
      logic              at_end;
      logic              sweep_last;
      logic              out_busy;
      logic [CELL_W-1:0] cursor;
      logic [COL_W-1:0]  col;
   } ctrl_status_type;

endpackage

@@ rtl/core/tcw_if.sv @@
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] char_code;
   logic [BYTE_W-1:0] attribute;
   logic [CELL_W-1:0] cell_address;

   modport source (output valid, output cmd, output char_code, output attribute,
                   output cell_address, input ready);
   modport sink   (input valid, input cmd, input char_code, input attribute,
                   input cell_address, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cursor_cell;
   logic [BYTE_W-1:0] read_char;
   logic [BYTE_W-1:0] read_attr;
   logic              scrolled;

   modport source (output valid, output cursor_cell, output read_char, output read_attr,
                   output scrolled, input ready);
   modport sink   (input valid, input cursor_cell, input read_char, input read_attr,
                   input scrolled, output ready);
endinterface

@@ rtl/core/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2000,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tcw_ctrl.sv @@
// Controller state machine: sequences puts, scroll, clear, fill, read and the reset sweep.
module tcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcw_pkg::ctrl_status_type status,
   output tcw_pkg::ctrl_cmd_type    cmd
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (status.req_cmd)
                  CMD_PUT, CMD_PUT_ATTR: state_in = status.at_end ? ST_SCROLL : ST_PUT;
                  CMD_CLEAR:             state_in = ST_CLEAR;
                  CMD_FILL:              state_in = ST_FILL;
                  CMD_READ:              state_in = ST_READ;
                  default:               state_in = ST_RESP;
               endcase
            end
         end
         ST_PUT: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (status.sweep_last) state_in = ST_SCROLL_END;
         end
         ST_SCROLL_END: state_in = ST_PUT;
         ST_CLEAR, ST_FILL: begin
            if (status.sweep_last) state_in = ST_RESP;
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      cmd.capture      = 1'b0;
      cmd.sweep_start  = 1'b0;
      cmd.sweep_step   = 1'b0;
      cmd.mem_op       = MEM_NONE;
      cmd.cur_op       = CUR_HOLD;
      cmd.load_rsp     = 1'b0;
      cmd.set_scrolled = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.mem_op     = MEM_INIT;
            cmd.sweep_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture     = 1'b1;
               cmd.sweep_start = 1'b1;
            end
         end
         ST_PUT: begin
            if (!status.out_busy) begin
               cmd.mem_op   = MEM_PUT;
               cmd.cur_op   = CUR_PUT;
               cmd.load_rsp = 1'b1;
            end
         end
         ST_SCROLL: begin
            cmd.mem_op       = MEM_SCROLL;
            cmd.sweep_step   = 1'b1;
            cmd.set_scrolled = 1'b1;
         end
         ST_SCROLL_END: cmd.cur_op = CUR_SCROLL;
         ST_CLEAR: begin
            cmd.mem_op     = MEM_CLEAR;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) cmd.cur_op = CUR_ZERO;
         end
         ST_FILL: begin
            cmd.mem_op     = MEM_FILL;
            cmd.sweep_step = 1'b1;
         end
         ST_READ: cmd.mem_op = MEM_READ;
         ST_RESP: begin
            if (!status.out_busy) cmd.load_rsp = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/core/tcw_dpath.sv @@
// Datapath: screen memories, cursor, sweep counter and response register.
module tcw_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_attribute,
   input  logic [tcw_pkg::CELL_W-1:0]    req_cell_address,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cursor_cell,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_char,
   output logic [tcw_pkg::BYTE_W-1:0]    rsp_read_attr,
   output logic                          rsp_scrolled,
   input  tcw_pkg::ctrl_cmd_type         cmd,
   output tcw_pkg::ctrl_status_type      status
);
   import tcw_pkg::*;

   logic [CMD_W-1:0]  cmd_ff;
   logic [BYTE_W-1:0] char_ff;
   logic [BYTE_W-1:0] attr_ff;
   logic [CELL_W-1:0] addr_ff;

   logic [CELL_W-1:0] sweep_ff, sweep_in;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              scrolled_ff, scrolled_in;

   logic              wr_pend_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              wr_space_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cursor_ff;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [BYTE_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic              rsp_scrolled_ff;

   logic              chr_wr_en, chr_rd_en, atr_wr_en, atr_rd_en;
   logic [ADDR_W-1:0] chr_wr_addr, chr_rd_addr, atr_wr_addr;
   logic [BYTE_W-1:0] chr_wr_data, atr_wr_data, chr_rd_data, atr_rd_data;
   logic [CELL_W:0]   scroll_src;
   logic              is_newline, read_hit;

   assign is_newline = (char_ff == NEWLINE_CODE);
   assign scroll_src = {1'b0, sweep_ff} + (CELL_W+1)'(COLUMNS);
   assign read_hit   = (cmd_ff == CMD_READ) && (addr_ff < CELL_W'(CELLS));

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_code;
         attr_ff <= req_attribute;
         addr_ff <= req_cell_address;
      end
   end

   // sweep counter, cursor, flags
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_start) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + CELL_W'(1);
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      case (cmd.cur_op)
         CUR_PUT: begin
            if (is_newline) begin
               cursor_in = cursor_ff + CELL_W'(COLUMNS) - CELL_W'(col_ff);
               col_in    = '0;
            end else begin
               cursor_in = cursor_ff + CELL_W'(1);
               col_in    = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
            end
         end
         CUR_SCROLL: begin
            cursor_in = CELL_W'(CELLS - COLUMNS);
            col_in    = '0;
         end
         CUR_ZERO: begin
            cursor_in = '0;
            col_in    = '0;
         end
         default: begin
            cursor_in = cursor_ff;
         end
      endcase
   end

   always_comb begin
      scrolled_in = scrolled_ff;
      if (cmd.capture) begin
         scrolled_in = 1'b0;
      end else if (cmd.set_scrolled) begin
         scrolled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff    <= '0;
         cursor_ff   <= '0;
         col_ff      <= '0;
         scrolled_ff <= 1'b0;
         wr_pend_ff  <= 1'b0;
      end else begin
         sweep_ff    <= sweep_in;
         cursor_ff   <= cursor_in;
         col_ff      <= col_in;
         scrolled_ff <= scrolled_in;
         wr_pend_ff  <= (cmd.mem_op == MEM_SCROLL);
      end
   end

   // scroll: read row below now, write one row up next cycle
   always_ff @(posedge clock) begin
      wr_addr_ff  <= sweep_ff[ADDR_W-1:0];
      wr_space_ff <= (sweep_ff >= CELL_W'(CELLS - COLUMNS));
   end

   // memory ports
   always_comb begin
      chr_wr_en   = 1'b0;
      chr_wr_addr = sweep_ff[ADDR_W-1:0];
      chr_wr_data = SPACE_CODE;
      atr_wr_en   = 1'b0;
      atr_wr_addr = sweep_ff[ADDR_W-1:0];
      atr_wr_data = '0;
      if (wr_pend_ff) begin
         chr_wr_en   = 1'b1;
         chr_wr_addr = wr_addr_ff;
         chr_wr_data = wr_space_ff ? SPACE_CODE : chr_rd_data;
      end
      case (cmd.mem_op)
         MEM_INIT: begin
            chr_wr_en   = 1'b1;
            chr_wr_data = '0;
            atr_wr_en   = 1'b1;
         end
         MEM_CLEAR: begin
            chr_wr_en   = 1'b1;
         end
         MEM_FILL: begin
            atr_wr_en   = 1'b1;
            atr_wr_data = attr_ff;
         end
         MEM_PUT: begin
            chr_wr_en   = !is_newline;
            chr_wr_addr = cursor_ff[ADDR_W-1:0];
            chr_wr_data = char_ff;
            atr_wr_en   = !is_newline && (cmd_ff == CMD_PUT_ATTR);
            atr_wr_addr = cursor_ff[ADDR_W-1:0];
            atr_wr_data = attr_ff;
         end
         default: begin
            atr_wr_data = '0;
         end
      endcase
   end

   assign chr_rd_en   = (cmd.mem_op == MEM_SCROLL) || (cmd.mem_op == MEM_READ);
   assign chr_rd_addr = (cmd.mem_op == MEM_SCROLL) ? scroll_src[ADDR_W-1:0]
                                                   : addr_ff[ADDR_W-1:0];
   assign atr_rd_en   = (cmd.mem_op == MEM_READ);

   tcw_ram #(.WIDTH(BYTE_W), .DEPTH(CELLS)) u_chars (
      .clock   (clock),
      .wr_en   (chr_wr_en),
      .wr_addr (chr_wr_addr),
      .wr_data (chr_wr_data),
      .rd_en   (chr_rd_en),
      .rd_addr (chr_rd_addr),
      .rd_data (chr_rd_data)
   );

   tcw_ram #(.WIDTH(BYTE_W), .DEPTH(CELLS)) u_attrs (
      .clock   (clock),
      .wr_en   (atr_wr_en),
      .wr_addr (atr_wr_addr),
      .wr_data (atr_wr_data),
      .rd_en   (atr_rd_en),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (atr_rd_data)
   );

   // response register
   assign rsp_char_in  = read_hit ? chr_rd_data : '0;
   assign rsp_attr_in  = read_hit ? atr_rd_data : '0;
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cursor_ff   <= cursor_in;
         rsp_char_ff     <= rsp_char_in;
         rsp_attr_ff     <= rsp_attr_in;
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_cell = rsp_cursor_ff;
   assign rsp_read_char   = rsp_char_ff;
   assign rsp_read_attr   = rsp_attr_ff;
   assign rsp_scrolled    = rsp_scrolled_ff;

   assign status.req_cmd    = req_cmd;
   assign status.at_end     = (cursor_ff >= CELL_W'(CELLS));
   assign status.sweep_last = (sweep_ff == CELL_W'(CELLS - 1));
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;
   assign status.cursor     = cursor_ff;
   assign status.col        = col_ff;

endmodule

@@ rtl/core/text_console_writer_unit.sv @@
// Clear and fill sweep every cell; a put at the end of the screen scrolls first.
// The sweeps are set by the one write port of each screen memory, one cell a cycle.
// The response register frees the request side while a response waits.
// After reset a clearing pass zeroes both memories with req.ready low;
// cursor is zero and no response is pending.
module text_console_writer_unit (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req,
   tcw_rsp_if.source   rsp
);
   import tcw_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req.cmd),
      .req_char_code    (req.char_code),
      .req_attribute    (req.attribute),
      .req_cell_address (req.cell_address),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_cursor_cell  (rsp.cursor_cell),
      .rsp_read_char    (rsp.read_char),
      .rsp_read_attr    (rsp.read_attr),
      .rsp_scrolled     (rsp.scrolled),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef SYNTHESIS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      status.cursor <= CELL_W'(CELLS))
      else $error("cursor beyond end of screen");

   a_end_at_row_start: assert property (@(posedge clock) disable iff (reset)
      (status.cursor == CELL_W'(CELLS)) |-> (status.col == '0))
      else $error("cursor at end of screen but column not zero");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while previous one still in work");
`endif

endmodule
